FILE: rtl/ppurse_pkg.sv
// Shared types, codes and constants of the picture-unit register block.
// No dependencies; every other file of the block but the interface file imports this package.
`timescale 1ns / 1ps

package ppurse_pkg;

   localparam int SPRITE_MEM_BYTES_DEF = 256;
   localparam int LINE_SLOTS_DEF       = 8;
   localparam int SPRITE_HEIGHT_DEF    = 8;
   localparam int QUEUE_DEPTH          = 2;

   // Function codes of an input item.
   localparam logic [2:0] FUNC_WRITE  = 3'd0;
   localparam logic [2:0] FUNC_READ   = 3'd1;
   localparam logic [2:0] FUNC_EVAL   = 3'd2;
   localparam logic [2:0] FUNC_VBLANK = 3'd3;
   localparam logic [2:0] FUNC_FRAME  = 3'd4;

   // Bus register numbers.
   localparam logic [2:0] REG_CONTROL  = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   localparam logic [7:0]  EMPTY_OFFSET = 8'hff;
   localparam logic [15:0] STEP_ALONG   = 16'd1;
   localparam logic [15:0] STEP_DOWN    = 16'd32;
   localparam int          CTRL_STEP_BIT = 2;
   localparam int          CTRL_IRQ_BIT  = 7;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ,
      OP_EVAL,
      OP_VBLANK,
      OP_FRAME
   } ppurse_op_type;

   typedef struct packed {
      ppurse_op_type op;
      logic [2:0]    reg_idx;
      logic [7:0]    wdata;
      logic [7:0]    line;
   } ppurse_cmd_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic [15:0] mem_addr;
      logic        mem_write;
      logic        mem_read;
      logic [7:0]  mem_wdata;
      logic [2:0]  slot;
      logic [7:0]  sprite_offset;
      logic        last;
      logic        irq;
   } ppurse_rsp_type;

endpackage

FILE: rtl/ppurse_if.sv
// Valid/ready channel interfaces for the request and result sides.
// No dependencies.
`timescale 1ns / 1ps

interface ppurse_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] reg_addr;
   logic [7:0] wdata;
   logic [7:0] line;

   modport source (output valid, func, reg_addr, wdata, line, input ready);
   modport sink   (input valid, func, reg_addr, wdata, line, output ready);
endinterface

interface ppurse_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rdata;
   logic [15:0] mem_addr;
   logic        mem_write;
   logic        mem_read;
   logic [7:0]  mem_wdata;
   logic [2:0]  slot;
   logic [7:0]  sprite_offset;
   logic        last;
   logic        irq;

   modport source (output valid, rdata, mem_addr, mem_write, mem_read, mem_wdata, slot,
                   sprite_offset, last, irq, input ready);
   modport sink   (input valid, rdata, mem_addr, mem_write, mem_read, mem_wdata, slot,
                   sprite_offset, last, irq, output ready);
endinterface

FILE: rtl/ppurse_front.sv
// Front end: takes request beats and classifies them into queue commands.
// Depends on ppurse_pkg and ppurse_req_if.
`timescale 1ns / 1ps

module ppurse_front import ppurse_pkg::*; (
   ppurse_req_if.sink      req,
   input  logic            q_full,
   output logic            q_push,
   output ppurse_cmd_type  q_data
);

   logic          reg_ok;
   ppurse_op_type op;

   assign reg_ok    = (req.reg_addr[7:3] == 5'd0);
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // Accesses that change nothing and return zero collapse into one no-op code.
   always_comb begin
      op = OP_NONE;
      unique case (req.func)
         FUNC_WRITE: begin
            if (reg_ok && req.reg_addr[2:0] != REG_STATUS) op = OP_WRITE;
         end
         FUNC_READ: begin
            if (reg_ok && req.reg_addr[2:0] != REG_OAM_ADDR
                && req.reg_addr[2:0] != REG_SCROLL) op = OP_READ;
         end
         FUNC_EVAL:   op = OP_EVAL;
         FUNC_VBLANK: op = OP_VBLANK;
         FUNC_FRAME:  op = OP_FRAME;
         default:     op = OP_NONE;
      endcase
   end

   always_comb begin
      q_data.op      = op;
      q_data.reg_idx = req.reg_addr[2:0];
      q_data.wdata   = req.wdata;
      q_data.line    = req.line;
   end

endmodule

FILE: rtl/ppurse_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on ppurse_pkg.
`timescale 1ns / 1ps

module ppurse_queue import ppurse_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ppurse_cmd_type  push_data,
   output logic            full,
   input  logic            pop,
   output ppurse_cmd_type  pop_data,
   output logic            empty
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(QUEUE_DEPTH);

   ppurse_cmd_type  entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      if (do_push && !do_pop)      count_in = count_ff + (AW + 1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (AW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/ppurse_back.sv
// Back end: register file, sprite attribute memory, line scan sequencer and
// the result register. Depends on ppurse_pkg and ppurse_rsp_if.
`timescale 1ns / 1ps

module ppurse_back import ppurse_pkg::*; #(
   parameter int SPRITE_MEM_BYTES = SPRITE_MEM_BYTES_DEF,
   parameter int LINE_SLOTS       = LINE_SLOTS_DEF,
   parameter int SPRITE_HEIGHT    = SPRITE_HEIGHT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  ppurse_cmd_type  q_data,
   output logic            q_pop,
   ppurse_rsp_if.source    rsp
);

   localparam int OAM_AW = $clog2(SPRITE_MEM_BYTES);
   localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
   localparam logic [8:0]        OAM_LIMIT = 9'(SPRITE_MEM_BYTES);
   localparam logic [8:0]        HEIGHT9   = 9'(SPRITE_HEIGHT);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINE_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_FILL = 4'b1000
   } ppurse_state_type;

   // The pointer is below four times the smallest memory, so three
   // conditional subtractions reduce it into range.
   function automatic logic [OAM_AW-1:0] oam_index(input logic [7:0] a);
      logic [8:0] v;
      v = {1'b0, a};
      for (int k = 0; k < 3; k++) begin
         if (v >= OAM_LIMIT) v = v - OAM_LIMIT;
      end
      return v[OAM_AW-1:0];
   endfunction

   ppurse_state_type   state_ff, state_in;
   ppurse_cmd_type     cmd_ff, cmd_in;
   logic [7:0]         control_ff, control_in;
   logic [7:0]         mask_ff, mask_in;
   logic               vblank_ff, vblank_in;
   logic               pending_ff, pending_in;
   logic [7:0]         scroll0_ff, scroll0_in;
   logic [7:0]         scroll1_ff, scroll1_in;
   logic [15:0]        vaddr_ff, vaddr_in;
   logic [7:0]         oam_ptr_ff, oam_ptr_in;
   logic [8:0]         cur_ff, cur_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ppurse_rsp_type     rsp_data_ff, rsp_data_in;

   logic [7:0]         oam_mem [SPRITE_MEM_BYTES];
   logic [7:0]         rd_data_ff;
   logic [OAM_AW-1:0]  rd_addr;
   logic [OAM_AW-1:0]  wr_addr;
   logic               mem_we;

   logic               out_free;
   logic               rsp_load;
   logic               hit;
   logic [8:0]         y9, line9, next_cur;
   logic [15:0]        step;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign y9       = {1'b0, rd_data_ff};
   assign line9    = {1'b0, cmd_ff.line};
   assign hit      = (line9 >= y9) && (line9 < y9 + HEIGHT9);
   assign next_cur = cur_ff + 9'd4;
   assign step     = control_ff[CTRL_STEP_BIT] ? STEP_DOWN : STEP_ALONG;
   assign wr_addr  = oam_index(oam_ptr_ff);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      control_in  = control_ff;
      mask_in     = mask_ff;
      vblank_in   = vblank_ff;
      pending_in  = pending_ff;
      scroll0_in  = scroll0_ff;
      scroll1_in  = scroll1_ff;
      vaddr_in    = vaddr_ff;
      oam_ptr_in  = oam_ptr_ff;
      cur_in      = cur_ff;
      slot_in     = slot_ff;
      rsp_data_in = rsp_data_ff;
      rsp_load    = 1'b0;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      rd_addr     = oam_index(oam_ptr_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               if (q_data.op == OP_EVAL) begin
                  cur_in  = {1'b0, oam_ptr_ff};
                  slot_in = '0;
                  // The read issued this cycle already fetches the first entry.
                  state_in = ({1'b0, oam_ptr_ff} >= OAM_LIMIT) ? ST_FILL : ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               rsp_data_in               = '0;
               rsp_data_in.sprite_offset = EMPTY_OFFSET;
               rsp_data_in.last          = 1'b1;
               unique case (cmd_ff.op)
                  OP_WRITE: begin
                     unique case (cmd_ff.reg_idx)
                        REG_CONTROL:  control_in = cmd_ff.wdata;
                        REG_MASK:     mask_in    = cmd_ff.wdata;
                        REG_OAM_ADDR: oam_ptr_in = cmd_ff.wdata;
                        REG_OAM_DATA: begin
                           mem_we     = 1'b1;
                           oam_ptr_in = oam_ptr_ff + 8'd1;
                        end
                        REG_SCROLL: begin
                           scroll0_in = scroll1_ff;
                           scroll1_in = cmd_ff.wdata;
                        end
                        REG_ADDR: vaddr_in = {2'b00, vaddr_ff[5:0], cmd_ff.wdata};
                        REG_DATA: begin
                           rsp_data_in.mem_addr  = vaddr_ff;
                           rsp_data_in.mem_write = 1'b1;
                           rsp_data_in.mem_wdata = cmd_ff.wdata;
                           vaddr_in              = vaddr_ff + step;
                        end
                        default: ;
                     endcase
                  end
                  OP_READ: begin
                     unique case (cmd_ff.reg_idx)
                        REG_CONTROL: rsp_data_in.rdata = control_ff;
                        REG_MASK:    rsp_data_in.rdata = mask_ff;
                        REG_STATUS: begin
                           rsp_data_in.rdata = {vblank_ff, 7'd0};
                           vblank_in         = 1'b0;
                        end
                        REG_OAM_DATA: rsp_data_in.rdata = rd_data_ff;
                        REG_ADDR:     rsp_data_in.rdata = vaddr_ff[7:0];
                        REG_DATA: begin
                           rsp_data_in.mem_addr = vaddr_ff;
                           rsp_data_in.mem_read = 1'b1;
                           vaddr_in             = vaddr_ff + step;
                        end
                        default: ;
                     endcase
                  end
                  OP_VBLANK: begin
                     vblank_in  = 1'b1;
                     pending_in = 1'b1;
                  end
                  OP_FRAME: begin
                     vblank_in  = 1'b0;
                     pending_in = 1'b0;
                  end
                  default: ;
               endcase
               rsp_data_in.irq = control_in[CTRL_IRQ_BIT] && pending_in;
               rsp_load        = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (hit && !out_free) begin
               // Hold the entry under test until the result register frees.
               rd_addr = cur_ff[OAM_AW-1:0];
            end else begin
               if (hit) begin
                  rsp_data_in               = '0;
                  rsp_data_in.slot          = 3'(slot_ff);
                  rsp_data_in.sprite_offset = cur_ff[7:0];
                  rsp_data_in.last          = (slot_ff == LAST_SLOT);
                  rsp_data_in.irq           = control_ff[CTRL_IRQ_BIT] && pending_ff;
                  rsp_load                  = 1'b1;
                  slot_in                   = slot_ff + SLOT_W'(1);
               end
               if (hit && slot_ff == LAST_SLOT) begin
                  state_in = ST_IDLE;
               end else if (next_cur >= OAM_LIMIT) begin
                  state_in = ST_FILL;
               end else begin
                  cur_in  = next_cur;
                  rd_addr = next_cur[OAM_AW-1:0];
               end
            end
         end

         ST_FILL: begin
            if (out_free) begin
               rsp_data_in               = '0;
               rsp_data_in.slot          = 3'(slot_ff);
               rsp_data_in.sprite_offset = EMPTY_OFFSET;
               rsp_data_in.last          = (slot_ff == LAST_SLOT);
               rsp_data_in.irq           = control_ff[CTRL_IRQ_BIT] && pending_ff;
               rsp_load                  = 1'b1;
               slot_in                   = slot_ff + SLOT_W'(1);
               if (slot_ff == LAST_SLOT) state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         control_ff   <= '0;
         mask_ff      <= '0;
         vblank_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         scroll0_ff   <= '0;
         scroll1_ff   <= '0;
         vaddr_ff     <= '0;
         oam_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         control_ff   <= control_in;
         mask_ff      <= mask_in;
         vblank_ff    <= vblank_in;
         pending_ff   <= pending_in;
         scroll0_ff   <= scroll0_in;
         scroll1_ff   <= scroll1_in;
         vaddr_ff     <= vaddr_in;
         oam_ptr_ff   <= oam_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cur_ff      <= cur_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) oam_mem[wr_addr] <= cmd_ff.wdata;
      rd_data_ff <= oam_mem[rd_addr];
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.rdata         = rsp_data_ff.rdata;
   assign rsp.mem_addr      = rsp_data_ff.mem_addr;
   assign rsp.mem_write     = rsp_data_ff.mem_write;
   assign rsp.mem_read      = rsp_data_ff.mem_read;
   assign rsp.mem_wdata     = rsp_data_ff.mem_wdata;
   assign rsp.slot          = rsp_data_ff.slot;
   assign rsp.sprite_offset = rsp_data_ff.sprite_offset;
   assign rsp.last          = rsp_data_ff.last;
   assign rsp.irq           = rsp_data_ff.irq;

endmodule

FILE: rtl/ppu_registers_and_sprite_evaluation.sv
// Picture-unit register interface with sprite memory and line sprite scan.
// A bus or frame beat is queued, popped, then executed once the result register is free.
// The sequencer pops a new beat only after it has executed the last; the queue holds the rest.
// A line scan pops its command, tests the entries from the OAM pointer on, one per memory read,
// then fills each empty slot; it tests at most 64 entries. Reset is synchronous: registers
// and queue clear; sprite memory holds no reset value.
`timescale 1ns / 1ps

module ppu_registers_and_sprite_evaluation import ppurse_pkg::*; #(
   parameter int SPRITE_MEM_BYTES = SPRITE_MEM_BYTES_DEF,
   parameter int LINE_SLOTS       = LINE_SLOTS_DEF,
   parameter int SPRITE_HEIGHT    = SPRITE_HEIGHT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ppurse_req_if.sink    req_ch,
   ppurse_rsp_if.source  rsp_ch
);

   logic            q_full, q_empty, q_push, q_pop;
   ppurse_cmd_type  q_in, q_out;

   ppurse_front u_front (
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_in)
   );

   ppurse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   ppurse_back #(
      .SPRITE_MEM_BYTES (SPRITE_MEM_BYTES),
      .LINE_SLOTS       (LINE_SLOTS),
      .SPRITE_HEIGHT    (SPRITE_HEIGHT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_out),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_ch.ready)
      else $error("request accepted while the command queue is full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty command queue");

   a_mem_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.mem_write && rsp_ch.mem_read))
      else $error("video memory read and write requested in one beat");

   a_mem_single: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.mem_write || rsp_ch.mem_read)
      |-> rsp_ch.last && rsp_ch.slot == 3'd0 && rsp_ch.sprite_offset == EMPTY_OFFSET)
      else $error("video memory request inside a sprite scan result");

endmodule

FILE: dv/tb_top.sv
// Testbench for the picture-unit register block: bus, frame and line-scan beats are driven in,
// and a shadow of the registers and sprite memory predicts each result beat, checked in order.
// Depends on ppurse_pkg, the two channel interfaces and ppu_registers_and_sprite_evaluation.
`timescale 1ns / 1ps

module tb_top;
   import ppurse_pkg::*;

   localparam int         CYCLE_LIMIT      = 300_000;
   localparam int         SETTLE_CYCLES    = 100;
   localparam int         RANDOM_PER_PHASE = 28;
   localparam int         BURST_LENGTH     = 6;
   localparam int         OAM_SAFE_BASE    = 216;
   localparam int         OAM_FILL_BYTES   = SPRITE_MEM_BYTES_DEF - OAM_SAFE_BASE;
   localparam int         SAFE_SPAN        = OAM_FILL_BYTES - 1;
   localparam logic [2:0] FUNC_SPARE_FIRST = FUNC_FRAME + 3'd1;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
   localparam logic [7:0] CTRL_IRQ_ENABLE  = 8'h80;
   localparam logic [7:0] CTRL_STEP_DOWN   = 8'h04;
   localparam logic [7:0] STATUS_VBLANK    = 8'h80;
   localparam logic [7:0] STATUS_HIT       = 8'h40;
   localparam logic [7:0] LAST_REG_NUMBER  = 8'd7;

   class ppu_register_shadow;
      logic [7:0]     control;
      logic [7:0]     mask;
      logic [7:0]     status;
      logic           vblank_pending;
      logic [7:0]     scroll [2];
      logic [15:0]    vaddr;
      logic [7:0]     oam_ptr;
      logic [7:0]     oam [SPRITE_MEM_BYTES_DEF];
      bit             written [SPRITE_MEM_BYTES_DEF];
      ppurse_rsp_type awaited [$];
      int             error_count;
      int             results_checked;
      int             requests;
      int             scans;
      int             sprites_found;
      int             mem_accesses;

      function new();
         control = '0;
         mask = '0;
         status = '0;
         vblank_pending = 1'b0;
         scroll[0] = '0;
         scroll[1] = '0;
         vaddr = '0;
         oam_ptr = '0;
         foreach (oam[i]) oam[i] = '0;
         foreach (written[i]) written[i] = 1'b0;
         error_count = 0;
         results_checked = 0;
         requests = 0;
         scans = 0;
         sprites_found = 0;
         mem_accesses = 0;
      endfunction

      function void step_vaddr();
         vaddr = vaddr + (control[CTRL_STEP_BIT] ? STEP_DOWN : STEP_ALONG);
         mem_accesses++;
      endfunction

      // A beat may only read sprite memory entries that have been written.
      function bit oam_legal(logic [2:0] func, logic [7:0] reg_addr);
         if (func == FUNC_READ && reg_addr == {5'd0, REG_OAM_DATA}) return written[oam_ptr];
         if (func == FUNC_EVAL) begin
            for (int i = oam_ptr; i < SPRITE_MEM_BYTES_DEF; i += 4) begin
               if (!written[i]) return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void note_request(logic [2:0] func, logic [7:0] reg_addr, logic [7:0] wdata,
                                 logic [7:0] line);
         ppurse_rsp_type r;
         int unsigned    found;
         int unsigned    y;
         r = '0;
         r.sprite_offset = EMPTY_OFFSET;
         requests++;
         if (func == FUNC_EVAL) begin
            // A scan leaves all state alone; slots fill in OAM order and the rest stay empty.
            found = 0;
            scans++;
            for (int i = oam_ptr; i < SPRITE_MEM_BYTES_DEF && found < LINE_SLOTS_DEF; i += 4) begin
               y = oam[i];
               if (line >= y && line < y + SPRITE_HEIGHT_DEF) begin
                  r.slot = 3'(found);
                  r.sprite_offset = 8'(i);
                  r.last = (found + 1 == LINE_SLOTS_DEF);
                  r.irq = control[CTRL_IRQ_BIT] & vblank_pending;
                  awaited.push_back(r);
                  found++;
                  sprites_found++;
               end
            end
            while (found < LINE_SLOTS_DEF) begin
               r.slot = 3'(found);
               r.sprite_offset = EMPTY_OFFSET;
               r.last = (found + 1 == LINE_SLOTS_DEF);
               r.irq = control[CTRL_IRQ_BIT] & vblank_pending;
               awaited.push_back(r);
               found++;
            end
            return;
         end
         if (func == FUNC_WRITE && reg_addr <= LAST_REG_NUMBER) begin
            case (reg_addr[2:0])
               REG_CONTROL:  control = wdata;
               REG_MASK:     mask = wdata;
               REG_OAM_ADDR: oam_ptr = wdata;
               REG_OAM_DATA: begin
                  oam[oam_ptr] = wdata;
                  written[oam_ptr] = 1'b1;
                  oam_ptr++;
               end
               REG_SCROLL: begin
                  scroll[0] = scroll[1];
                  scroll[1] = wdata;
               end
               REG_ADDR:     vaddr = {2'b00, vaddr[5:0], wdata};
               REG_DATA: begin
                  r.mem_addr = vaddr;
                  r.mem_write = 1'b1;
                  r.mem_wdata = wdata;
                  step_vaddr();
               end
               default: ;
            endcase
         end else if (func == FUNC_READ && reg_addr <= LAST_REG_NUMBER) begin
            case (reg_addr[2:0])
               REG_CONTROL:  r.rdata = control;
               REG_MASK:     r.rdata = mask;
               REG_STATUS: begin
                  r.rdata = status;
                  status = status & ~STATUS_VBLANK;
               end
               REG_OAM_DATA: r.rdata = oam[oam_ptr];
               REG_ADDR:     r.rdata = vaddr[7:0];
               REG_DATA: begin
                  r.mem_addr = vaddr;
                  r.mem_read = 1'b1;
                  step_vaddr();
               end
               default: ;
            endcase
         end else if (func == FUNC_VBLANK) begin
            status = status | STATUS_VBLANK;
            vblank_pending = 1'b1;
         end else if (func == FUNC_FRAME) begin
            status = status & ~(STATUS_VBLANK | STATUS_HIT);
            vblank_pending = 1'b0;
         end
         r.last = 1'b1;
         r.irq = control[CTRL_IRQ_BIT] & vblank_pending;
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] expected, logic [15:0] actual);
         if (actual !== expected) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
            error_count++;
         end
      endfunction

      function void check_result(ppurse_rsp_type seen);
         ppurse_rsp_type want;
         if (awaited.size() == 0) begin
            $error("Result beat with nothing awaited: slot %0d, offset 0x%0h",
                   seen.slot, seen.sprite_offset);
            error_count++;
            return;
         end
         want = awaited.pop_front();
         results_checked++;
         compare_field("rdata", want.rdata, seen.rdata);
         compare_field("mem_addr", want.mem_addr, seen.mem_addr);
         compare_field("mem_write", want.mem_write, seen.mem_write);
         compare_field("mem_read", want.mem_read, seen.mem_read);
         compare_field("mem_wdata", want.mem_wdata, seen.mem_wdata);
         compare_field("slot", want.slot, seen.slot);
         compare_field("sprite_offset", want.sprite_offset, seen.sprite_offset);
         compare_field("last", want.last, seen.last);
         compare_field("irq", want.irq, seen.irq);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   ppurse_req_if       req_bus ();
   ppurse_rsp_if       rsp_bus ();
   ppu_register_shadow shadow;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 cycle_count = 0;
   int                 useful_beats = 0;

   ppu_registers_and_sprite_evaluation i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $error("Run stopped after %0d cycles with %0d result beats outstanding",
             cycle_count, shadow.awaited.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      ppurse_rsp_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '0;
         seen.rdata = rsp_bus.rdata;
         seen.mem_addr = rsp_bus.mem_addr;
         seen.mem_write = rsp_bus.mem_write;
         seen.mem_read = rsp_bus.mem_read;
         seen.mem_wdata = rsp_bus.mem_wdata;
         seen.slot = rsp_bus.slot;
         seen.sprite_offset = rsp_bus.sprite_offset;
         seen.last = rsp_bus.last;
         seen.irq = rsp_bus.irq;
         shadow.check_result(seen);
      end
   end

   // Called just after a falling edge; returns just after the falling edge that follows
   // acceptance, so valid is only ever assigned once per time step.
   task automatic drive_beat(input logic [2:0] func, input logic [7:0] reg_addr,
                             input logic [7:0] wdata, input logic [7:0] line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.reg_addr <= reg_addr;
      req_bus.wdata <= wdata;
      req_bus.line <= line;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      shadow.note_request(func, reg_addr, wdata, line);
      if (func <= FUNC_FRAME && (func >= FUNC_EVAL || reg_addr <= LAST_REG_NUMBER))
         useful_beats++;
      @(negedge clock);
   endtask

   // A beat that would read unwritten sprite memory first has the pointer moved back into
   // the part that the opening fill wrote.
   task automatic send_beat(input logic [2:0] func, input logic [7:0] reg_addr,
                            input logic [7:0] wdata, input logic [7:0] line);
      if (!shadow.oam_legal(func, reg_addr))
         drive_beat(FUNC_WRITE, {5'd0, REG_OAM_ADDR},
                    8'(OAM_SAFE_BASE + $urandom_range(SAFE_SPAN)), 8'($urandom));
      drive_beat(func, reg_addr, wdata, line);
   endtask

   task automatic bus_write(input logic [2:0] reg_idx, input logic [7:0] data);
      send_beat(FUNC_WRITE, {5'd0, reg_idx}, data, 8'($urandom));
   endtask

   task automatic bus_read(input logic [2:0] reg_idx);
      send_beat(FUNC_READ, {5'd0, reg_idx}, 8'($urandom), 8'($urandom));
   endtask

   task automatic scan_line(input logic [7:0] line);
      send_beat(FUNC_EVAL, 8'($urandom), 8'($urandom), line);
   endtask

   task automatic frame_event(input logic [2:0] func);
      send_beat(func, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (shadow.awaited.size() != 0) @(negedge clock);
   endtask

   // A line that some sprite reachable from the current OAM pointer covers, or just misses.
   function automatic logic [7:0] covering_line();
      int span;
      span = (SPRITE_MEM_BYTES_DEF - 1 - shadow.oam_ptr) / 4;
      return shadow.oam[shadow.oam_ptr + 4 * $urandom_range(span)]
             + 8'($urandom_range(SPRITE_HEIGHT_DEF + 1));
   endfunction

   task automatic random_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // Upload a few sprite bytes, point at a sprite and scan a line.
         bus_write(REG_OAM_ADDR, ($urandom_range(3) == 0) ? 8'($urandom)
                                                          : 8'({$urandom_range(63), 2'b00}));
         repeat ($urandom_range(1, 8))
            bus_write(REG_OAM_DATA, ($urandom_range(1) == 0) ? 8'($urandom_range(40))
                                                             : 8'($urandom));
         bus_write(REG_OAM_ADDR, ($urandom_range(3) == 0) ? 8'($urandom)
                                 : 8'(OAM_SAFE_BASE + 4 * $urandom_range(SAFE_SPAN / 4)));
         if ($urandom_range(3) == 0) bus_read(REG_OAM_DATA);
         scan_line(($urandom_range(4) == 0) ? 8'($urandom) : covering_line());
      end else if (pick < 50) begin
         if ($urandom_range(1) == 0) bus_write(REG_CONTROL, 8'($urandom));
         bus_write(REG_ADDR, 8'($urandom));
         bus_write(REG_ADDR, 8'($urandom));
         if ($urandom_range(1) == 0) bus_read(REG_ADDR);
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 0) bus_write(REG_DATA, 8'($urandom));
            else bus_read(REG_DATA);
         end
      end else if (pick < 65) begin
         bus_write(REG_CONTROL, 8'($urandom));
         frame_event(FUNC_VBLANK);
         repeat ($urandom_range(2)) bus_read(REG_STATUS);
         if ($urandom_range(1) == 0) scan_line(covering_line());
         frame_event(FUNC_FRAME);
      end else if (pick < 80) begin
         case ($urandom_range(3))
            0: begin
               bus_write(REG_MASK, 8'($urandom));
               bus_read(REG_MASK);
            end
            1: begin
               bus_write(REG_SCROLL, 8'($urandom));
               bus_write(REG_SCROLL, 8'($urandom));
               bus_read(REG_SCROLL);
            end
            2: begin
               bus_write(REG_STATUS, 8'($urandom));
               bus_read(REG_STATUS);
            end
            default: begin
               bus_read(REG_CONTROL);
               bus_read(REG_OAM_ADDR);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 3))
            send_beat(3'($urandom), ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom),
                      8'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct);
      int target;
      send_idle_pct = sender_pct;
      recv_stall_pct = receiver_pct;
      target = useful_beats + RANDOM_PER_PHASE;
      while (useful_beats < target) random_sequence();
      // Hold the sender back until the block has returned everything.
      drain();
   endtask

   initial begin
      logic [7:0] fill_byte;
      shadow = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_WRITE;
      req_bus.reg_addr = '0;
      req_bus.wdata = '0;
      req_bus.line = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the top of sprite memory first; every scan and read stays inside that part.
      // Nine sprites there sit on lines 16 to 19, so line 20 overflows the slots.
      bus_write(REG_OAM_ADDR, 8'(OAM_SAFE_BASE));
      for (int i = 0; i < OAM_FILL_BYTES; i++) begin
         if (i % 4 == 0 && i < OAM_FILL_BYTES - 4) fill_byte = 8'(16 + (i / 4) % 4);
         else if (i == OAM_FILL_BYTES - 4) fill_byte = 8'hff;
         else fill_byte = 8'($urandom);
         bus_write(REG_OAM_DATA, fill_byte);
      end

      bus_read(REG_CONTROL);
      bus_read(REG_STATUS);
      bus_read(REG_OAM_ADDR);
      bus_read(REG_SCROLL);
      bus_write(REG_MASK, 8'hff);
      bus_read(REG_MASK);
      bus_write(REG_CONTROL, CTRL_IRQ_ENABLE);
      frame_event(FUNC_VBLANK);
      bus_read(REG_STATUS);
      bus_read(REG_STATUS);
      bus_write(REG_STATUS, 8'hff);
      frame_event(FUNC_FRAME);
      bus_write(REG_SCROLL, 8'h00);
      bus_write(REG_SCROLL, 8'hff);
      bus_write(REG_ADDR, 8'hff);
      bus_write(REG_ADDR, 8'hff);
      bus_read(REG_ADDR);
      bus_write(REG_DATA, 8'h5a);
      bus_read(REG_DATA);
      bus_write(REG_OAM_ADDR, 8'(OAM_SAFE_BASE));
      scan_line(8'd20);
      scan_line(8'd0);
      scan_line(8'd255);
      // A sprite found at the very last byte reads the same as an empty slot.
      bus_write(REG_OAM_ADDR, 8'hff);
      bus_read(REG_OAM_DATA);
      scan_line(shadow.oam[SPRITE_MEM_BYTES_DEF - 1]);
      send_beat(FUNC_WRITE, 8'hff, 8'hff, 8'h00);
      send_beat(FUNC_READ, 8'h08, 8'h00, 8'hff);
      send_beat(FUNC_SPARE_FIRST, 8'h00, 8'h00, 8'h00);
      send_beat(FUNC_SPARE_LAST, 8'hff, 8'hff, 8'hff);

      // Step the video address by 32 from near the top of the 14-bit range and past it.
      bus_write(REG_CONTROL, CTRL_STEP_DOWN);
      bus_write(REG_ADDR, 8'h3f);
      bus_write(REG_ADDR, 8'he0);
      repeat (BURST_LENGTH) begin
         if ($urandom_range(1) == 0) bus_write(REG_DATA, 8'($urandom));
         else bus_read(REG_DATA);
      end
      drain();

      run_phase(28, 59);
      run_phase(59, 28);
      run_phase(0, 0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.awaited.size() != 0) begin
         $error("%0d result beats never arrived", shadow.awaited.size());
         shadow.error_count++;
      end
      $display("Checked %0d result beats from %0d request beats; %0d line scans found %0d sprites.",
               shadow.results_checked, shadow.requests, shadow.scans, shadow.sprites_found);
      $display("Video memory saw %0d data accesses.", shadow.mem_accesses);
      if (shadow.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
